>>> sv/hdtm_pkg.sv
// Shared types, constants and the sRGB threshold table for the tone mapper.
`default_nettype none
package hdtm_pkg;

	localparam int DIV_STEPS  = 25;
	localparam int SRCH_STEPS = 8;
	localparam int NSTG       = 2 + DIV_STEPS + 1 + SRCH_STEPS;

	localparam logic [24:0] ONE_Q24 = 25'h100_0000;

	typedef enum logic [1:0] {
		REG_EXPOSURE_GAIN  = 2'd0,
		REG_DIAG_MODE      = 2'd1,
		REG_DIAG_INV_SCALE = 2'd2
	} cfg_reg_t;

	localparam logic [3:0] MODE_SCATTER_A = 4'd0;
	localparam logic [3:0] MODE_SCATTER_B = 4'd4;

	typedef struct packed {
		logic [31:0] exposure_gain;
		logic [3:0]  diag_mode;
		logic [31:0] diag_inv_scale;
	} cfg_t;

	typedef struct packed {
		logic [NSTG-1:0] ld;
	} pipe_ctl_t;

	typedef logic [24:0] thr_tab_t [256];

	// True when the display code of linear value v is at least k.
	function automatic logic code_at_least(logic [24:0] v, int k);
		logic [63:0]  vl;
		logic [299:0] a;
		logic [299:0] b;
		int           i;
		vl = {39'b0, v};
		if (vl * 64'd10000000 <= 64'd31308 * 64'd16777216) begin
			return (64'd329460 * vl + 64'd50 * 64'd16777216) >= 64'(k) * 64'd1677721600;
		end
		a = 300'd1;
		for (i = 0; i < 5; i++) a = a * {275'b0, v};
		for (i = 0; i < 12; i++) a = a * 300'd10761;
		b = 300'd1;
		for (i = 0; i < 12; i++) b = b * 300'(40 * k + 541);
		b = b << 120;
		return a >= b;
	endfunction

	// Smallest linear value that reaches each display code.
	function automatic thr_tab_t build_thr();
		thr_tab_t    t;
		int          k;
		logic [25:0] lo;
		logic [25:0] hi;
		logic [25:0] mid;
		t[0] = '0;
		for (k = 1; k < 256; k++) begin
			lo = '0;
			hi = {1'b0, ONE_Q24};
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				if (code_at_least(mid[24:0], k)) hi = mid;
				else lo = mid + 26'd1;
			end
			t[k] = lo[24:0];
		end
		return t;
	endfunction

	localparam thr_tab_t SRGB_THR = build_thr();

endpackage
`default_nettype wire

>>> sv/hdtm_ctrl.sv
// Valid chain and per-stage load enables for the lane pipeline.
`default_nettype none
module hdtm_ctrl
	import hdtm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	output pipe_ctl_t      ctl
);

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] rdy;

	always_comb begin
		rdy[NSTG-1] = !vld_q[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign ctl.ld    = rdy;
	assign in_ready  = rdy[0];
	assign out_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NSTG; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/hdtm_lane.sv
// One channel lane: gain product, Reinhard divider, clamp and sRGB code search.
`default_nettype none
module hdtm_lane
	import hdtm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [31:0] x,
	input  wire cfg_t        cfg,
	input  wire pipe_ctl_t   ctl,
	output logic [7:0]       code
);

	logic        scat;
	logic [31:0] mult;

	assign scat = (cfg.diag_mode == MODE_SCATTER_A) || (cfg.diag_mode == MODE_SCATTER_B);
	assign mult = scat ? cfg.exposure_gain : cfg.diag_inv_scale;

	logic [63:0] prod_s1;
	logic        scat_s1;

	always_ff @(posedge clk) begin
		if (ctl.ld[0]) begin
			prod_s1 <= 64'(x) * 64'(mult);
			scat_s1 <= scat;
		end
	end

	logic [64:0] den_s2;
	logic [24:0] vdiag_s2;
	logic        scat_s2;

	always_ff @(posedge clk) begin
		if (ctl.ld[1]) begin
			den_s2  <= {1'b0, prod_s1} + 65'h1_0000_0000;
			scat_s2 <= scat_s1;
			if ((|prod_s1[63:33]) || (prod_s1[32:8] > ONE_Q24)) vdiag_s2 <= ONE_Q24;
			else vdiag_s2 <= prod_s1[32:8];
		end
	end

	logic [64:0] rem_s3   [DIV_STEPS];
	logic [24:0] quo_s3   [DIV_STEPS];
	logic [64:0] den_s3   [DIV_STEPS];
	logic [24:0] vdiag_s3 [DIV_STEPS];
	logic        scat_s3  [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [64:0] rem_i;
		logic [24:0] quo_i;
		logic [64:0] den_i;
		logic [24:0] vd_i;
		logic        sc_i;
		logic [65:0] sh;
		logic        ge;
		if (j == 0) begin : g_first
			assign rem_i = 65'h0_8000_0000;
			assign quo_i = '0;
			assign den_i = den_s2;
			assign vd_i  = vdiag_s2;
			assign sc_i  = scat_s2;
		end else begin : g_next
			assign rem_i = rem_s3[j-1];
			assign quo_i = quo_s3[j-1];
			assign den_i = den_s3[j-1];
			assign vd_i  = vdiag_s3[j-1];
			assign sc_i  = scat_s3[j-1];
		end
		assign sh = {rem_i, 1'b0};
		assign ge = sh >= {1'b0, den_i};
		always_ff @(posedge clk) begin
			if (ctl.ld[2+j]) begin
				rem_s3[j]   <= ge ? 65'(sh - {1'b0, den_i}) : sh[64:0];
				quo_s3[j]   <= {quo_i[23:0], ge};
				den_s3[j]   <= den_i;
				vdiag_s3[j] <= vd_i;
				scat_s3[j]  <= sc_i;
			end
		end
	end

	logic [24:0] recip;
	logic [24:0] v_s4;

	assign recip = quo_s3[DIV_STEPS-1] + {24'b0, |rem_s3[DIV_STEPS-1]};

	always_ff @(posedge clk) begin
		if (ctl.ld[2+DIV_STEPS]) begin
			v_s4 <= scat_s3[DIV_STEPS-1] ? 25'(ONE_Q24 - recip) : vdiag_s3[DIV_STEPS-1];
		end
	end

	logic [7:0]  code_s5 [SRCH_STEPS];
	logic [24:0] v_s5    [SRCH_STEPS];

	for (genvar j = 0; j < SRCH_STEPS; j++) begin : g_srch
		logic [7:0]  code_i;
		logic [24:0] v_i;
		logic [7:0]  cand;
		if (j == 0) begin : g_first
			assign code_i = '0;
			assign v_i    = v_s4;
		end else begin : g_next
			assign code_i = code_s5[j-1];
			assign v_i    = v_s5[j-1];
		end
		assign cand = code_i | (8'h80 >> j);
		always_ff @(posedge clk) begin
			if (ctl.ld[3+DIV_STEPS+j]) begin
				code_s5[j] <= (v_i >= SRGB_THR[cand]) ? cand : code_i;
				v_s5[j]    <= v_i;
			end
		end
	end

	assign code = code_s5[SRCH_STEPS-1];

endmodule
`default_nettype wire

>>> sv/hdr_tone_map_srgb.sv
// Top level: config registers, three channel lanes and the shared pipeline control.
// 36 register stages lie between input accept and output valid.
// One pixel per cycle when not stalled; pipelined 25-step Reinhard divider in each lane.
// Stalls back up stage by stage; empty stages keep filling while the output waits.
// Reset clears all valid bits and loads the default register values.
`default_nettype none
module hdr_tone_map_srgb
	import hdtm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] red_in,
	input  wire logic [31:0] green_in,
	input  wire logic [31:0] blue_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       red_code,
	output logic [7:0]       green_code,
	output logic [7:0]       blue_code
);

	cfg_t      cfg_q;
	pipe_ctl_t ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exposure_gain  <= 32'd65536;
			cfg_q.diag_mode      <= MODE_SCATTER_A;
			cfg_q.diag_inv_scale <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_EXPOSURE_GAIN:  cfg_q.exposure_gain  <= cfg_data;
				REG_DIAG_MODE:      cfg_q.diag_mode      <= cfg_data[3:0];
				REG_DIAG_INV_SCALE: cfg_q.diag_inv_scale <= cfg_data;
				default: ;
			endcase
		end
	end

	hdtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	hdtm_lane u_red (
		.clk  (clk),
		.x    (red_in),
		.cfg  (cfg_q),
		.ctl  (ctl),
		.code (red_code)
	);

	hdtm_lane u_green (
		.clk  (clk),
		.x    (green_in),
		.cfg  (cfg_q),
		.ctl  (ctl),
		.code (green_code)
	);

	hdtm_lane u_blue (
		.clk  (clk),
		.x    (blue_in),
		.cfg  (cfg_q),
		.ctl  (ctl),
		.code (blue_code)
	);

endmodule
`default_nettype wire

>>> sv/hdtm_checker.sv
// Port-level checks for the tone mapper, bound to the top level.
`default_nettype none
module hdtm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] red_code,
	input wire logic [7:0] green_code,
	input wire logic [7:0] blue_code
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input word dropped before accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_code) &&
		$stable(green_code) && $stable(blue_code))
		else $error("output word changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid && in_ready)
		else $error("pipeline not empty after reset");

endmodule

bind hdr_tone_map_srgb hdtm_checker u_hdtm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.red_code   (red_code),
	.green_code (green_code),
	.blue_code  (blue_code)
);
`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the HDR tone mapper with sRGB encoding.
`default_nettype none
module testbench
	import hdtm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int         LIMIT    = 400000;
	localparam int         NDIR     = 20;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_code_t;

	typedef struct packed {
		logic [31:0] r;
		logic [31:0] g;
		logic [31:0] b;
		logic        typed;
		pixel_code_t code;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] red_in = '0;
	logic [31:0] green_in = '0;
	logic [31:0] blue_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  red_code;
	logic [7:0]  green_code;
	logic [7:0]  blue_code;

	logic [31:0] gain_q = 32'd65536;
	logic [3:0]  mode_q = MODE_SCATTER_A;
	logic [31:0] inv_scale_q = 32'd65536;

	pixel_code_t pending_codes[$];
	int          errors = 0;
	int          cycles = 0;
	int          pixels_sent = 0;
	int          pixels_checked = 0;
	int          hold_ready = 0;
	bit          long_hold_req = 0;
	bit          steady = 0;
	dir_row_t    dir_rows[NDIR];

	hdr_tone_map_srgb uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_code(red_code), .green_code(green_code), .blue_code(blue_code)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_codes.size());
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] encode_srgb(logic [24:0] v);
		logic [63:0]  vv;
		logic [319:0] lhs;
		logic [319:0] rhs;
		int           lo;
		int           hi;
		int           mid;
		int           i;
		vv = {39'b0, v};
		if (vv * 64'd10000000 <= 64'd31308 * 64'd16777216)
			return 8'((64'd329460 * vv + 64'd50 * 64'd16777216) / 64'd1677721600);
		lhs = 320'd1;
		for (i = 0; i < 5; i++) lhs = lhs * {295'b0, v};
		for (i = 0; i < 12; i++) lhs = lhs * 320'd10761;
		lo = 0;
		hi = 255;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			rhs = 320'd1;
			for (i = 0; i < 12; i++) rhs = rhs * 320'(40 * mid + 541);
			rhs = rhs << 120;
			if (lhs >= rhs) lo = mid;
			else hi = mid - 1;
		end
		return 8'(lo);
	endfunction

	function automatic logic [7:0] tone_map(logic [31:0] x);
		logic [63:0] p;
		logic [63:0] d;
		logic [63:0] q;
		logic [24:0] v;
		if (mode_q == MODE_SCATTER_A || mode_q == MODE_SCATTER_B) begin
			p = 64'(x) * 64'(gain_q);
			d = p + (64'd1 << 32);
			q = (64'd1 << 56) / d;
			if ((64'd1 << 56) % d != 0) q = q + 64'd1;
			v = ONE_Q24 - 25'(q);
		end else begin
			p = (64'(x) * 64'(inv_scale_q)) >> 8;
			v = (p > 64'(ONE_Q24)) ? ONE_Q24 : 25'(p);
		end
		return encode_srgb(v);
	endfunction

	function automatic logic [31:0] rand_chan();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4) return $urandom;
		if (sel < 9) return $urandom >> $urandom_range(0, 31);
		case ($urandom_range(0, 2))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return 32'h0001_0000;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		wait (pending_codes.size() == 0);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_EXPOSURE_GAIN:  gain_q = val;
			REG_DIAG_MODE:      mode_q = val[3:0];
			REG_DIAG_INV_SCALE: inv_scale_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
		logic typed, pixel_code_t code);
		int          gap;
		pixel_code_t want;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		do @(posedge clk); while (!in_ready);
		if (typed) want = code;
		else want = '{tone_map(r), tone_map(g), tone_map(b)};
		pending_codes.push_back(want);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic send_random(int n);
		repeat (n) send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0, '0);
		in_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_ready > 0) begin
			hold_ready <= hold_ready - 1;
			out_ready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req <= 0;
			hold_ready <= 300;
			out_ready <= 1'b0;
		end else if (!steady && $urandom_range(0, 99) < 30) begin
			hold_ready <= ($urandom_range(0, 9) < 9) ? $urandom_range(0, 3)
				: $urandom_range(10, 40);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pixel_code_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_codes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word r=%0d g=%0d b=%0d",
						red_code, green_code, blue_code);
			end else begin
				want = pending_codes.pop_front();
				pixels_checked++;
				if (want.r !== red_code || want.g !== green_code
					|| want.b !== blue_code) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
							want.r, want.g, want.b, red_code, green_code, blue_code);
				end
			end
		end
	end

	initial begin
		int i;
		// first half runs at reset settings, second half in diagnostic mode 1
		dir_rows[0]  = '{32'd0, 32'd0, 32'd0, 1'b1, '{8'd0, 8'd0, 8'd0}};
		dir_rows[1]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0};
		dir_rows[2]  = '{32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 1'b0, '0};
		dir_rows[3]  = '{32'd1, 32'd2, 32'd3, 1'b0, '0};
		dir_rows[4]  = '{32'h0000_00CD, 32'h0000_00CE, 32'h0000_00CC, 1'b0, '0};
		dir_rows[5]  = '{32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 1'b0, '0};
		dir_rows[6]  = '{32'h7FFF_FFFF, 32'h0000_FFFF, 32'h0100_0000, 1'b0, '0};
		dir_rows[7]  = '{32'h0000_0100, 32'h0000_1000, 32'h0010_0000, 1'b0, '0};
		dir_rows[8]  = '{32'h0003_0000, 32'h0000_4000, 32'h0000_2000, 1'b0, '0};
		dir_rows[9]  = '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b0, '0};
		dir_rows[10] = '{32'd0, 32'd0, 32'd0, 1'b1, '{8'd0, 8'd0, 8'd0}};
		dir_rows[11] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{8'd255, 8'd255, 8'd255}};
		dir_rows[12] = '{32'h0001_0000, 32'h0001_0001, 32'h0002_0000, 1'b1,
			'{8'd255, 8'd255, 8'd255}};
		dir_rows[13] = '{32'h0000_FFFF, 32'h0000_8000, 32'h0000_0100, 1'b0, '0};
		dir_rows[14] = '{32'h0000_00CD, 32'h0000_00CE, 32'h0000_0001, 1'b0, '0};
		dir_rows[15] = '{32'h0000_0033, 32'h0000_0034, 32'h0000_0C00, 1'b0, '0};
		dir_rows[16] = '{32'h0000_4000, 32'h0000_2000, 32'h0000_1000, 1'b0, '0};
		dir_rows[17] = '{32'h5555_5555, 32'h0000_AAAA, 32'h0000_5555, 1'b0, '0};
		dir_rows[18] = '{32'h0000_00FF, 32'h0000_0FFF, 32'h0000_7FFF, 1'b0, '0};
		dir_rows[19] = '{32'h0000_0010, 32'h0000_0080, 32'h0000_0800, 1'b0, '0};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < NDIR; i++) begin
			if (i == 10) begin
				in_valid <= 1'b0;
				write_reg(REG_DIAG_MODE, 32'd1);
			end
			send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b,
				dir_rows[i].typed, dir_rows[i].code);
		end
		in_valid <= 1'b0;

		write_reg(REG_DIAG_MODE, 32'(MODE_SCATTER_A));
		write_reg(REG_EXPOSURE_GAIN, 32'd0);
		send_random(30);
		write_reg(REG_EXPOSURE_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_DIAG_MODE, 32'(MODE_SCATTER_B));
		steady = 1;
		send_random(30);
		steady = 0;
		write_reg(REG_EXPOSURE_GAIN, 32'h0000_0400);
		long_hold_req = 1;
		send_random(60);
		write_reg(REG_DIAG_MODE, 32'd15);
		write_reg(REG_DIAG_INV_SCALE, 32'd0);
		send_random(30);
		write_reg(REG_DIAG_INV_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_DIAG_MODE, 32'd7);
		send_random(30);
		write_reg(REG_DIAG_INV_SCALE, 32'd65536);
		write_reg(REG_NONE, 32'hFFFF_FFFF);
		send_random(40);
		repeat (6) begin
			write_reg(REG_EXPOSURE_GAIN, $urandom >> $urandom_range(0, 24));
			write_reg(REG_DIAG_INV_SCALE, $urandom >> $urandom_range(0, 24));
			write_reg(REG_DIAG_MODE, ($urandom_range(0, 1) == 1)
				? 32'($urandom_range(0, 15)) : 32'(MODE_SCATTER_A));
			send_random(35);
		end

		wait (pending_codes.size() == 0);
		repeat (40) @(posedge clk);
		$display("sent %0d pixels, checked %0d across exposure, scatter and diagnostic",
			pixels_sent, pixels_checked);
		$display("settings including zero and full-scale gains, mismatches: %0d", errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
